// ----- sv/ecd_pkg.sv -----
// Shared types, control-word layout and calendar constants for the
// epoch-to-calendar converter. No dependencies.
`default_nettype none

package ecd_pkg;

    // Calendar constants
    localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
    localparam logic [15:0] EPOCH_WEEKDAY = 16'd4;
    localparam logic [15:0] FEB_LAST_DOY  = 16'd58;
    localparam logic [5:0]  LAST_WEEK_DAY = 6'd25;
    localparam logic [11:0] NO_LEAP_YEAR  = 12'd2100;
    localparam logic [3:0]  FIRST_MONTH   = 4'd1;
    localparam logic [3:0]  LAST_MONTH    = 4'd12;
    localparam logic [3:0]  MONTH_MARCH   = 4'd3;
    localparam logic [3:0]  MONTH_OCTOBER = 4'd10;
    localparam logic [4:0]  LAST_HOUR     = 5'd23;
    localparam logic [4:0]  SWITCH_HOUR   = 5'd2;
    localparam logic [2:0]  LAST_WEEKDAY  = 3'd6;
    localparam logic [2:0]  SUNDAY        = 3'd0;

    // Datapath operations
    typedef logic [3:0] op_t;
    localparam op_t OP_LOAD      = 4'd0;
    localparam op_t OP_DIV       = 4'd1;
    localparam op_t OP_SAVE_SEC  = 4'd2;
    localparam op_t OP_SAVE_MIN  = 4'd3;
    localparam op_t OP_SAVE_HOUR = 4'd4;
    localparam op_t OP_SAVE_WDAY = 4'd5;
    localparam op_t OP_YEAR      = 4'd6;
    localparam op_t OP_FEB       = 4'd7;
    localparam op_t OP_MONTH     = 4'd8;
    localparam op_t OP_DAY       = 4'd9;
    localparam op_t OP_DST       = 4'd10;
    localparam op_t OP_EMIT      = 4'd11;
    localparam op_t OP_NOP       = 4'd12;

    // Jump conditions
    typedef logic [2:0] cond_t;
    localparam cond_t COND_NEVER      = 3'd0;
    localparam cond_t COND_NO_INPUT   = 3'd1;
    localparam cond_t COND_YEAR_MORE  = 3'd3;
    localparam cond_t COND_MONTH_MORE = 3'd4;
    localparam cond_t COND_OUT_FULL   = 3'd5;

    // Divisor select
    typedef logic [1:0] dsel_t;
    localparam dsel_t DSEL_60 = 2'd0;
    localparam dsel_t DSEL_24 = 2'd1;
    localparam dsel_t DSEL_7  = 2'd2;

    typedef logic [3:0] step_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        dsel_t dsel;
        step_t target;
    } ctrl_t;

    // Status from the datapath
    typedef struct packed {
        logic year_more;
        logic month_more;
    } dp_flags_t;

    // All jump conditions seen by the sequencer
    typedef struct packed {
        logic      in_valid;
        logic      out_full;
        dp_flags_t dp;
    } flags_t;

    typedef struct packed {
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic [2:0]  wday;
        logic        summer;
    } res_t;

    // Leap rule over 1970..2106: every fourth year except 2100
    function automatic logic is_leap(input logic [11:0] y);
        return (y[1:0] == 2'b00) && (y != NO_LEAP_YEAR);
    endfunction

    // Month lengths on the 366-day table
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd2:    len = 5'd29;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- sv/ecd_seq.sv -----
// Microcode sequencer: step counter, control-word table and jump logic.
// Depends on ecd_pkg.
`default_nettype none

module ecd_seq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ecd_pkg::flags_t flags,
    output ecd_pkg::ctrl_t       ctrl
);
    import ecd_pkg::*;

    // Program steps
    localparam step_t S_DIV_SEC   = 4'd0;
    localparam step_t S_SAVE_SEC  = 4'd1;
    localparam step_t S_DIV_MIN   = 4'd2;
    localparam step_t S_SAVE_MIN  = 4'd3;
    localparam step_t S_DIV_HOUR  = 4'd4;
    localparam step_t S_SAVE_HOUR = 4'd5;
    localparam step_t S_DIV_WDAY  = 4'd6;
    localparam step_t S_SAVE_WDAY = 4'd7;
    localparam step_t S_YEAR      = 4'd8;
    localparam step_t S_FEB       = 4'd9;
    localparam step_t S_MONTH     = 4'd10;
    localparam step_t S_DAY       = 4'd11;
    localparam step_t S_DST       = 4'd12;
    localparam step_t S_EMIT      = 4'd13;
    localparam step_t S_SPARE     = 4'd14;
    localparam step_t S_IDLE      = 4'd15;

    step_t pc_reg;
    step_t pc_next;
    logic  take;

    // Control store; falling through the idle step wraps to step zero
    function automatic ctrl_t ucode(input step_t pc);
        ctrl_t w;
        case (pc)
            S_DIV_SEC:   w = '{OP_DIV,       COND_NEVER,      DSEL_60, S_IDLE};
            S_SAVE_SEC:  w = '{OP_SAVE_SEC,  COND_NEVER,      DSEL_60, S_IDLE};
            S_DIV_MIN:   w = '{OP_DIV,       COND_NEVER,      DSEL_60, S_IDLE};
            S_SAVE_MIN:  w = '{OP_SAVE_MIN,  COND_NEVER,      DSEL_60, S_IDLE};
            S_DIV_HOUR:  w = '{OP_DIV,       COND_NEVER,      DSEL_24, S_IDLE};
            S_SAVE_HOUR: w = '{OP_SAVE_HOUR, COND_NEVER,      DSEL_24, S_IDLE};
            S_DIV_WDAY:  w = '{OP_DIV,       COND_NEVER,      DSEL_7,  S_IDLE};
            S_SAVE_WDAY: w = '{OP_SAVE_WDAY, COND_NEVER,      DSEL_7,  S_IDLE};
            S_YEAR:      w = '{OP_YEAR,      COND_YEAR_MORE,  DSEL_60, S_YEAR};
            S_FEB:       w = '{OP_FEB,       COND_NEVER,      DSEL_60, S_IDLE};
            S_MONTH:     w = '{OP_MONTH,     COND_MONTH_MORE, DSEL_60, S_MONTH};
            S_DAY:       w = '{OP_DAY,       COND_NEVER,      DSEL_60, S_IDLE};
            S_DST:       w = '{OP_DST,       COND_NEVER,      DSEL_60, S_IDLE};
            S_EMIT:      w = '{OP_EMIT,      COND_OUT_FULL,   DSEL_60, S_EMIT};
            S_SPARE:     w = '{OP_NOP,       COND_NEVER,      DSEL_60, S_IDLE};
            default:     w = '{OP_LOAD,      COND_NO_INPUT,   DSEL_60, S_IDLE};
        endcase
        return w;
    endfunction

    assign ctrl = ucode(pc_reg);

    // Evaluate the jump condition
    always_comb
    begin
        case (ctrl.cond)
            COND_NEVER:      take = 1'b0;
            COND_NO_INPUT:   take = !flags.in_valid;
            COND_YEAR_MORE:  take = flags.dp.year_more;
            COND_MONTH_MORE: take = flags.dp.month_more;
            COND_OUT_FULL:   take = flags.out_full;
            default:         take = 1'b0;
        endcase
        pc_next = take ? ctrl.target : pc_reg + 4'd1;
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/ecd_dp.sv -----
// Datapath: reciprocal-multiply constant divider, year and month walk,
// summer time. Driven by control words from ecd_seq. Depends on ecd_pkg.
`default_nettype none

module ecd_dp (
    input  wire logic            clk,
    input  wire ecd_pkg::ctrl_t  ctrl,
    input  wire logic [31:0]     epoch_seconds,
    output ecd_pkg::dp_flags_t   dpf,
    output ecd_pkg::res_t        res
);
    import ecd_pkg::*;

    logic [31:0] quo_reg, quo_next;
    logic [31:0] qt_reg, qt_next;
    logic [15:0] days_reg, days_next;
    logic [11:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  min_reg, min_next;
    logic [5:0]  sec_reg, sec_next;
    logic [2:0]  wday_reg, wday_next;
    logic        summer_reg, summer_next;

    logic [31:0] magic;
    logic [63:0] product;
    logic [31:0] quot;
    logic [31:0] qt_mul;
    logic [31:0] rem;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic        in_season;
    logic        after_last;
    logic        summer;
    logic [2:0]  wday_inc;

    // Reciprocal of the divisor for the current pass
    always_comb
    begin
        case (ctrl.dsel)
            DSEL_60: magic = 32'h8888_8889;
            DSEL_24: magic = 32'hAAAA_AAAB;
            DSEL_7:  magic = 32'h2492_4925;
            default: magic = 32'h8888_8889;
        endcase
    end

    // Divide step: quotient from the high bits of the product
    assign product = {32'd0, quo_reg} * {32'd0, magic};

    // Save step: quotient times divisor, remainder by subtraction
    always_comb
    begin
        case (ctrl.dsel)
            DSEL_60:
            begin
                quot   = {5'd0, product[63:37]};
                qt_mul = (qt_reg << 6) - (qt_reg << 2);
            end
            DSEL_24:
            begin
                quot   = {4'd0, product[63:36]};
                qt_mul = (qt_reg << 4) + (qt_reg << 3);
            end
            DSEL_7:
            begin
                quot   = product[63:32];
                qt_mul = (qt_reg << 3) - qt_reg;
            end
            default:
            begin
                quot   = {5'd0, product[63:37]};
                qt_mul = (qt_reg << 6) - (qt_reg << 2);
            end
        endcase
    end

    assign rem = quo_reg - qt_mul;

    // Year and month lengths
    assign ylen = is_leap(year_reg) ? 9'd366 : 9'd365;
    assign mlen = month_len(month_reg);

    assign dpf.year_more  = (days_reg >= {7'd0, ylen});
    assign dpf.month_more = (month_reg < LAST_MONTH) && (days_reg >= {11'd0, mlen});

    // Summer time: last Sunday at or after day 25, switch at 02:00
    assign in_season  = (month_reg >= MONTH_MARCH) && (month_reg <= MONTH_OCTOBER);
    assign after_last = ({1'b0, day_reg} >= ({3'd0, wday_reg} + LAST_WEEK_DAY))
                        && ((wday_reg != SUNDAY) || (hour_reg >= SWITCH_HOUR));
    assign summer     = in_season && (after_last ? (month_reg != MONTH_OCTOBER)
                                                 : (month_reg != MONTH_MARCH));
    assign wday_inc   = (wday_reg == LAST_WEEKDAY) ? 3'd0 : wday_reg + 3'd1;

    // Next-value logic per operation
    always_comb
    begin
        quo_next    = quo_reg;
        qt_next     = qt_reg;
        days_next   = days_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        min_next    = min_reg;
        sec_next    = sec_reg;
        wday_next   = wday_reg;
        summer_next = summer_reg;
        case (ctrl.op)
            OP_LOAD:
            begin
                quo_next = epoch_seconds;
            end
            OP_DIV:
            begin
                qt_next = quot;
            end
            OP_SAVE_SEC:
            begin
                sec_next = rem[5:0];
                quo_next = qt_reg;
            end
            OP_SAVE_MIN:
            begin
                min_next = rem[5:0];
                quo_next = qt_reg;
            end
            OP_SAVE_HOUR:
            begin
                hour_next = rem[4:0];
                days_next = qt_reg[15:0];
                quo_next  = {16'd0, qt_reg[15:0] + EPOCH_WEEKDAY};
                year_next = EPOCH_YEAR;
            end
            OP_SAVE_WDAY:
            begin
                wday_next = rem[2:0];
            end
            OP_YEAR:
            begin
                if (dpf.year_more)
                begin
                    days_next = days_reg - {7'd0, ylen};
                    year_next = year_reg + 12'd1;
                end
            end
            OP_FEB:
            begin
                // Common year: skip 29 February
                if (!is_leap(year_reg) && (days_reg > FEB_LAST_DOY))
                begin
                    days_next = days_reg + 16'd1;
                end
                month_next = FIRST_MONTH;
            end
            OP_MONTH:
            begin
                if (dpf.month_more)
                begin
                    days_next  = days_reg - {11'd0, mlen};
                    month_next = month_reg + 4'd1;
                end
            end
            OP_DAY:
            begin
                day_next = days_reg[4:0] + 5'd1;
            end
            OP_DST:
            begin
                summer_next = summer;
                if (summer)
                begin
                    if (hour_reg == LAST_HOUR)
                    begin
                        // Carry the added hour into the next day
                        hour_next = 5'd0;
                        wday_next = wday_inc;
                        if (day_reg == mlen)
                        begin
                            day_next   = 5'd1;
                            month_next = month_reg + 4'd1;
                        end
                        else
                        begin
                            day_next = day_reg + 5'd1;
                        end
                    end
                    else
                    begin
                        hour_next = hour_reg + 5'd1;
                    end
                end
            end
            default:
            begin
                quo_next = quo_reg;
            end
        endcase
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        quo_reg    <= quo_next;
        qt_reg     <= qt_next;
        days_reg   <= days_next;
        year_reg   <= year_next;
        month_reg  <= month_next;
        day_reg    <= day_next;
        hour_reg   <= hour_next;
        min_reg    <= min_next;
        sec_reg    <= sec_next;
        wday_reg   <= wday_next;
        summer_reg <= summer_next;
    end

    assign res.sec    = sec_reg;
    assign res.min    = min_reg;
    assign res.hour   = hour_reg;
    assign res.day    = day_reg;
    assign res.month  = month_reg;
    assign res.year   = year_reg;
    assign res.wday   = wday_reg;
    assign res.summer = summer_reg;

endmodule

`default_nettype wire

// ----- sv/epoch_seconds_to_calendar_dst_top.sv -----
// Epoch seconds to calendar date with European summer time.
//
// Input channel: epoch_seconds with in_valid/in_ready; one transfer per
// conversion. Output channel: the calendar fields with out_valid/out_ready,
// one transfer per input.
// One item at a time: in_ready is high only while the sequencer sits in
// its idle step. A conversion's length from the input transfer to the
// output register depends on the years walked from 1970 (0..136) and
// the month reached (1..12), since both are walked one step at a time.
// The four constant divides (by 60, 60, 24, 7) use a reciprocal multiply
// and take two steps each; the year walk sets most of the rest. After the
// result is loaded, the sequencer goes through its spare step back to idle
// before it can take the next input. A new input can be taken while
// the previous result still waits; if the receiver stalls while a second
// result is ready, the sequencer holds in its emit step and in_ready stays low.
// Reset returns the sequencer to idle and drops out_valid; no other state.
// Depends on ecd_pkg, ecd_seq and ecd_dp.
`default_nettype none

module epoch_seconds_to_calendar_dst_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] epoch_seconds,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [5:0]       second_of_minute,
    output logic [5:0]       minute_of_hour,
    output logic [4:0]       hour_of_day,
    output logic [4:0]       day_of_month,
    output logic [3:0]       month_of_year,
    output logic [11:0]      calendar_year,
    output logic [2:0]       day_of_week,
    output logic             summer_time
);
    import ecd_pkg::*;

    ctrl_t     ctrl;
    flags_t    flags;
    dp_flags_t dpf;
    res_t      res;
    res_t      out_reg;
    logic      out_valid_reg, out_valid_next;
    logic      emit_fire;

    assign flags.in_valid = in_valid;
    assign flags.out_full = out_valid_reg && !out_ready;
    assign flags.dp       = dpf;

    ecd_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    ecd_dp u_dp (
        .clk           (clk),
        .ctrl          (ctrl),
        .epoch_seconds (epoch_seconds),
        .dpf           (dpf),
        .res           (res)
    );

    assign in_ready  = (ctrl.op == OP_LOAD);
    assign emit_fire = (ctrl.op == OP_EMIT) && !flags.out_full;

    // Hold the result until the receiver takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the output register on emit
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_reg <= res;
        end
    end

    assign out_valid        = out_valid_reg;
    assign second_of_minute = out_reg.sec;
    assign minute_of_hour   = out_reg.min;
    assign hour_of_day      = out_reg.hour;
    assign day_of_month     = out_reg.day;
    assign month_of_year    = out_reg.month;
    assign calendar_year    = out_reg.year;
    assign day_of_week      = out_reg.wday;
    assign summer_time      = out_reg.summer;

`ifndef SYNTHESIS
    // The block goes busy right after taking an input
    a_busy_after_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready still high after input transfer");

    // An emit always presents a result in the next cycle
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> out_valid)
        else $error("emit did not raise out_valid");

    // Presented results are well formed
    a_fields_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (month_of_year >= 4'd1 && month_of_year <= 4'd12
                       && day_of_week <= 3'd6 && hour_of_day <= 5'd23
                       && day_of_month >= 5'd1))
        else $error("result field out of range");

    // Summer time only between March and October
    a_summer_season: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && summer_time) |-> (month_of_year >= 4'd3 && month_of_year <= 4'd10))
        else $error("summer time flagged outside its season");
`endif

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking bench for epoch_seconds_to_calendar_dst_top: directed and random
// epoch counts through the valid/ready channels, checked against a date predictor.
// Depends on ecd_pkg (result struct) and the converter RTL.

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_PERIOD     = 12;
    localparam int unsigned RESET_CYCLES   = 9;
    localparam int unsigned RANDOM_ITEMS   = 1000;
    localparam int unsigned DRAIN_AT_ITEM  = 500;
    localparam int unsigned TAIL_CYCLES    = 320;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned MAX_REPORTS    = 10;

    // Holds expected dates in transfer order and checks results against them
    class calendar_check;

        typedef struct {
            logic [31:0]   seconds;
            ecd_pkg::res_t date;
        } expected_date_t;

        expected_date_t expected_dates[$];
        int unsigned    mismatches;

        function new();
            mismatches = 0;
        endfunction

        static function bit leap_year(input int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        // Month length on the 366-day calendar (February always 29)
        static function int unsigned month_span(input int unsigned m);
            if (m == 2)
                return 29;
            return 30 + ((m + (m >> 3)) & 1);
        endfunction

        // Work out the local date and time, summer hour included
        static function ecd_pkg::res_t date_of(input logic [31:0] secs);
            int unsigned   rest;
            int unsigned   days;
            int unsigned   yr;
            int unsigned   ylen;
            int unsigned   mon;
            int unsigned   dy;
            int unsigned   hr;
            int unsigned   wd;
            int            diff;
            bit            summer;
            ecd_pkg::res_t r;
            rest = secs;
            r.sec = 6'(rest % 60);
            rest = rest / 60;
            r.min = 6'(rest % 60);
            rest = rest / 60;
            hr = rest % 24;
            days = rest / 24;
            // 1970-01-01 fell on a Thursday
            wd = (days + 4) % 7;

            // Walk whole years off the day count
            yr = 1970;
            ylen = leap_year(yr) ? 366 : 365;
            while (days >= ylen)
            begin
                days -= ylen;
                yr++;
                ylen = leap_year(yr) ? 366 : 365;
            end

            // Step over 29 February in a common year
            if (ylen == 365 && days > 58)
                days++;

            mon = 1;
            while (mon < 12 && days >= month_span(mon))
            begin
                days -= month_span(mon);
                mon++;
            end
            dy = days + 1;

            // Summer time from the last Sunday of March 02:00 to that of October
            if (mon < 3 || mon > 10)
                summer = 1'b0;
            else
            begin
                diff = int'(dy) - int'(wd);
                if (diff >= 25 && (wd != 0 || hr >= 2))
                    summer = (mon != 10);
                else
                    summer = (mon != 3);
            end

            // Add the summer hour and carry into day, weekday and month
            if (summer)
            begin
                hr++;
                if (hr == 24)
                begin
                    hr = 0;
                    wd = (wd + 1) % 7;
                    if (dy == month_span(mon))
                    begin
                        dy = 0;
                        mon++;
                    end
                    dy++;
                end
            end

            r.hour   = 5'(hr);
            r.day    = 5'(dy);
            r.month  = 4'(mon);
            r.year   = 12'(yr);
            r.wday   = 3'(wd);
            r.summer = summer;
            return r;
        endfunction

        function void note_seconds(input logic [31:0] secs);
            expected_date_t e;
            e.seconds = secs;
            e.date = date_of(secs);
            expected_dates.push_back(e);
        endfunction

        function int unsigned pending();
            return expected_dates.size();
        endfunction

        function void check_date(input ecd_pkg::res_t got);
            expected_date_t e;
            bit             bad;
            if (expected_dates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result with nothing expected: %0d-%0d-%0d %0d:%0d:%0d",
                             got.year, got.month, got.day, got.hour, got.min, got.sec);
                return;
            end
            e = expected_dates.pop_front();
            bad = (got.sec    != e.date.sec)   || (got.min   != e.date.min)   ||
                  (got.hour   != e.date.hour)  || (got.day   != e.date.day)   ||
                  (got.month  != e.date.month) || (got.year  != e.date.year)  ||
                  (got.wday   != e.date.wday)  || (got.summer != e.date.summer);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("mismatch for %0d: expected %0d-%0d-%0d %0d:%0d:%0d wd %0d st %0d",
                             e.seconds, e.date.year, e.date.month, e.date.day,
                             e.date.hour, e.date.min, e.date.sec, e.date.wday,
                             e.date.summer);
                    $display("    actual %0d-%0d-%0d %0d:%0d:%0d wd %0d st %0d",
                             got.year, got.month, got.day, got.hour, got.min, got.sec,
                             got.wday, got.summer);
                end
            end
        endfunction

    endclass

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    logic [31:0]   epoch_seconds;
    logic          out_valid;
    logic          out_ready;
    logic [5:0]    second_of_minute;
    logic [5:0]    minute_of_hour;
    logic [4:0]    hour_of_day;
    logic [4:0]    day_of_month;
    logic [3:0]    month_of_year;
    logic [11:0]   calendar_year;
    logic [2:0]    day_of_week;
    logic          summer_time;
    ecd_pkg::res_t out_date;
    calendar_check board;
    int unsigned   idle_cycles;

    epoch_seconds_to_calendar_dst_top i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .epoch_seconds    (epoch_seconds),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .second_of_minute (second_of_minute),
        .minute_of_hour   (minute_of_hour),
        .hour_of_day      (hour_of_day),
        .day_of_month     (day_of_month),
        .month_of_year    (month_of_year),
        .calendar_year    (calendar_year),
        .day_of_week      (day_of_week),
        .summer_time      (summer_time)
    );

    assign out_date = '{sec: second_of_minute, min: minute_of_hour, hour: hour_of_day,
                        day: day_of_month, month: month_of_year, year: calendar_year,
                        wday: day_of_week, summer: summer_time};

    initial
    begin
        clk = 1'b0;
        forever
            #(CLK_PERIOD / 2.0) clk = ~clk;
    end

    // Check every output transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_date(out_date);
    end

    // Abort when neither channel has moved for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver: ready runs with stalls of mixed length, some long enough
    // to hold a second result in the converter
    initial
    begin
        int unsigned run_len;
        int unsigned stall_len;
        out_ready = 1'b0;
        forever
        begin
            run_len = $urandom_range(1, 60);
            repeat (run_len) @(negedge clk) out_ready = 1'b1;
            case ($urandom_range(0, 7))
                0, 1:    stall_len = 0;
                7:       stall_len = $urandom_range(100, 250);
                default: stall_len = $urandom_range(1, 20);
            endcase
            repeat (stall_len) @(negedge clk) out_ready = 1'b0;
        end
    end

    // Seconds count for a day of year and second of day in a given year
    function automatic logic [31:0] epoch_of(input int unsigned year, input int unsigned doy,
                                             input int unsigned sod);
        longint unsigned days;
        days = doy;
        for (int unsigned y = 1970; y < year; y++)
            days += calendar_check::leap_year(y) ? 366 : 365;
        return 32'(days * 86400 + sod);
    endfunction

    // Mix of uniform counts and times near switches and boundaries
    function automatic logic [31:0] random_seconds();
        int unsigned year;
        int unsigned feb;
        int unsigned doy;
        int unsigned sod;
        int unsigned mon;
        year = $urandom_range(1970, 2105);
        feb = calendar_check::leap_year(year) ? 29 : 28;
        case ($urandom_range(0, 9))
            5, 6:
            begin
                // last week of March or October, often right at 02:00
                if ($urandom_range(0, 1))
                    doy = 31 + feb + 24 + $urandom_range(0, 6);
                else
                    doy = 245 + feb + 24 + $urandom_range(0, 6);
                sod = $urandom_range(0, 1) ? $urandom_range(7195, 7204)
                                           : $urandom_range(0, 86399);
                return epoch_of(year, doy, sod);
            end
            7:
            begin
                // last hour of a summer month, so the extra hour carries
                mon = $urandom_range(3, 10);
                doy = 0;
                for (int unsigned m = 1; m < mon; m++)
                    doy += (m == 2) ? feb : calendar_check::month_span(m);
                doy += calendar_check::month_span(mon) - 1;
                return epoch_of(year, doy, $urandom_range(82800, 86399));
            end
            8:
            begin
                // new year, end of February and start of March
                case ($urandom_range(0, 3))
                    0:       doy = 0;
                    1:       doy = 58;
                    2:       doy = 59;
                    default: doy = feb + 336;
                endcase
                sod = $urandom_range(0, 1) ? $urandom_range(0, 59)
                                           : $urandom_range(86340, 86399);
                return epoch_of(year, doy, sod);
            end
            9:
            begin
                if ($urandom_range(0, 1))
                    return 32'($urandom_range(0, 1 << 20));
                return 32'hFFFF_FFFF - 32'($urandom_range(0, 1 << 20));
            end
            default:
                return $urandom();
        endcase
    endfunction

    // Present one count and hold it until the transfer
    task automatic send_seconds(input logic [31:0] value);
        @(negedge clk);
        in_valid = 1'b1;
        epoch_seconds = value;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_seconds(value);
    endtask

    task automatic drop_valid(input int unsigned cycles);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic wait_drained();
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] corner_values[$];
        int unsigned sent;
        int unsigned burst;
        bit          drained;
        rst_n = 1'b0;
        in_valid = 1'b0;
        epoch_seconds = '0;
        idle_cycles = 0;
        board = new();
        drained = 1'b0;

        corner_values = '{
            32'd0,                  // epoch start, Thursday
            32'hFFFF_FFFF,          // last count, February 2106
            32'hAAAA_AAAA, 32'h5555_5555,
            32'd1521331200 + 32'd10800, // Sunday in March, not the last one
            32'd1521932400,         // Saturday before the March switch
            32'd1521943199,         // last Sunday of March is the 25th
            32'd1521943200,
            32'd1616896799,         // March switch 2021, just before and at 02:00
            32'd1616896800,
            32'd1635645599,         // October switch 2021, just before and at 02:00
            32'd1635645600,
            32'd1617233400,         // 31 March 23:30, carries into April
            32'd1625094000,         // 30 June 23:00, carries into July
            32'd951825600,          // leap day of a 400th year
            32'd946684799,          // turn of the year 1999 to 2000
            32'd946684800,
            32'd4107542399,         // 2100 is a common year
            32'd4107542400,
            32'd2147483647,
            32'd2147483648
        };

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed corners back to back, then let the pipe empty
        foreach (corner_values[i])
            send_seconds(corner_values[i]);
        drop_valid(0);
        wait_drained();

        // Random bursts with gaps of mixed length
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 8);
            repeat (burst)
            begin
                send_seconds(random_seconds());
                sent++;
            end
            if (!drained && sent >= DRAIN_AT_ITEM)
            begin
                drop_valid(0);
                wait_drained();
                drained = 1'b1;
            end
            else if ($urandom_range(0, 3) != 0)
                drop_valid($urandom_range(0, 300));
        end

        drop_valid(0);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.mismatches == 0 && board.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
